// File: hw/rtl/quaternion_to_euler_angles_core_macros.svh
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH

// implication checked on every rising edge outside reset
`define QTE_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define QTE_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// File: hw/rtl/qte_pkg.sv
`timescale 1ns / 1ps
package qte_pkg;

    localparam int QTE_COMP_W   = 16;
    localparam int QTE_PROD_W   = 32;
    localparam int QTE_SUM_W    = 35;
    localparam int QTE_CORDIC_W = 38;
    localparam int QTE_ROOT_W   = 29;
    localparam int QTE_RAD_W    = 57;
    localparam int QTE_TURN_W   = 32;
    localparam int QTE_ANGLE_W  = 16;
    localparam int QTE_ATAN_LEN = 24;

    localparam logic signed [QTE_SUM_W-1:0] QTE_ONE_Q28 = QTE_SUM_W'(64'sd268435456);
    localparam logic [QTE_ANGLE_W-1:0] QTE_PITCH_POS = 16'h4000;
    localparam logic [QTE_ANGLE_W-1:0] QTE_PITCH_NEG = 16'hC000;
    localparam logic [QTE_TURN_W-1:0]  QTE_QUARTER   = 32'h4000_0000;
    localparam logic [QTE_TURN_W-1:0]  QTE_MINUS_QTR = 32'hC000_0000;
    localparam logic [QTE_TURN_W-1:0]  QTE_ROUND     = 32'h0000_8000;

    typedef struct packed {
        logic signed [QTE_SUM_W-1:0] sr;
        logic signed [QTE_SUM_W-1:0] cr;
        logic signed [QTE_SUM_W-1:0] sp;
        logic signed [QTE_SUM_W-1:0] sy;
        logic signed [QTE_SUM_W-1:0] cy;
        logic                        clamp;
        logic                        neg;
    } t_side;

    typedef struct packed {
        logic clamp;
        logic neg;
    } t_flag;

    // atan(2^-i) in turn units, 2^32 = 2 pi
    function automatic logic [QTE_TURN_W-1:0] qte_atan(input logic [4:0] idx);
        logic [QTE_TURN_W-1:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/quaternion_to_euler_angles_core.sv
`timescale 1ns / 1ps
// Quaternion to ZYX Euler angle converter.
// Input stream: one word per quaternion, tdata = {z, y, x, w}, each Q2.14 signed
// (16384 = 1.0). Output stream: tdata = {yaw, pitch, roll}, binary angles with
// 32768 = pi; tuser flags a pitch clamped to +-pi/2 because |2(wy - zx)| >= 1.
// Throughput: one word per cycle while o_s_tready is high. From input accept to
// output valid the word passes through products, sums, clamp test,
// a squarer, a 29-stage bit-per-stage square root, then three vectoring CORDIC
// pipelines side by side, one per angle.
// The whole datapath advances on one enable. An output register plus a skid
// register sit at the end, so input stays ready while a finished word waits;
// only when the skid register is also full does o_s_tready drop, and every word
// in flight holds its place until the sink takes one.
// Reset (synchronous, active low) empties the pipeline and both output
// registers; no word is lost or duplicated across a stall.
`include "quaternion_to_euler_angles_core_macros.svh"
module quaternion_to_euler_angles_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic [0:0]  o_m_tuser    // pitch_clamped
);
    import qte_pkg::*;

    localparam int SQ0   = 5;
    localparam int CD0   = SQ0 + QTE_ROOT_W;
    localparam int NVAL  = CD0 + CORDIC_STAGES + 1;
    localparam int LAST  = CD0 - 1;

    logic en;
    logic [NVAL-1:0] r_v;

    logic signed [QTE_COMP_W-1:0] w_w, w_x, w_y, w_z;
    logic signed [QTE_PROD_W-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;

    t_side r_side [1:LAST];
    t_side w_side2;
    logic signed [QTE_SUM_W-1:0] w_abs;
    logic [27:0]                 r_abs;
    logic [55:0]                 r_sq;
    logic [QTE_RAD_W-1:0]        r_rad;
    logic [QTE_ROOT_W-1:0]       w_root;
    logic signed [QTE_SUM_W-1:0] w_cp;

    t_flag r_flag [CORDIC_STAGES+1];

    logic [QTE_ANGLE_W-1:0] w_roll, w_pitch_c, w_yaw, w_pitch;
    logic [47:0] w_data;
    logic        w_inc_v;

    logic        r_ov, r_sk_v;
    logic [47:0] r_od, r_sk_d;
    logic        r_ou, r_sk_u;

    assign en         = !r_sk_v;
    assign o_s_tready = en;

    assign w_w = i_s_tdata[15:0];
    assign w_x = i_s_tdata[31:16];
    assign w_y = i_s_tdata[47:32];
    assign w_z = i_s_tdata[63:48];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NVAL-2:0], i_s_tvalid};
        end
    end

    // products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= w_w * w_x;
            r_yz <= w_y * w_z;
            r_xx <= w_x * w_x;
            r_yy <= w_y * w_y;
            r_wy <= w_w * w_y;
            r_zx <= w_z * w_x;
            r_wz <= w_w * w_z;
            r_xy <= w_x * w_y;
            r_zz <= w_z * w_z;
        end
    end

    always_comb begin
        w_side2       = r_side[1];
        w_side2.clamp = (r_side[1].sp >= QTE_ONE_Q28) || (r_side[1].sp <= -QTE_ONE_Q28);
        w_side2.neg   = r_side[1].sp[QTE_SUM_W-1];
    end

    // magnitude fits 28 bits whenever pitch is not clamped
    assign w_abs = r_side[1].sp[QTE_SUM_W-1] ? -r_side[1].sp : r_side[1].sp;

    // product sums, then the side chain that waits for the square root
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[1].sr    <= (QTE_SUM_W'(r_wx) + QTE_SUM_W'(r_yz)) <<< 1;
            r_side[1].cr    <= QTE_ONE_Q28 - ((QTE_SUM_W'(r_xx) + QTE_SUM_W'(r_yy)) <<< 1);
            r_side[1].sp    <= (QTE_SUM_W'(r_wy) - QTE_SUM_W'(r_zx)) <<< 1;
            r_side[1].sy    <= (QTE_SUM_W'(r_wz) + QTE_SUM_W'(r_xy)) <<< 1;
            r_side[1].cy    <= QTE_ONE_Q28 - ((QTE_SUM_W'(r_yy) + QTE_SUM_W'(r_zz)) <<< 1);
            r_side[1].clamp <= 1'b0;
            r_side[1].neg   <= 1'b0;
            r_side[2] <= w_side2;
            r_abs     <= w_abs[27:0];
            r_sq      <= 56'(r_abs) * 56'(r_abs);
            r_rad     <= (QTE_RAD_W'(1) << 56) - QTE_RAD_W'(r_sq);
            for (int k = 3; k <= LAST; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    qte_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_rad),
        .o_root (w_root)
    );

    assign w_cp = $signed({{(QTE_SUM_W-QTE_ROOT_W){1'b0}}, w_root});

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (r_side[LAST].cr),
        .i_y     (r_side[LAST].sr),
        .o_angle (w_roll)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (w_cp),
        .i_y     (r_side[LAST].sp),
        .o_angle (w_pitch_c)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (r_side[LAST].cy),
        .i_y     (r_side[LAST].sy),
        .o_angle (w_yaw)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flag[0].clamp <= r_side[LAST].clamp;
            r_flag[0].neg   <= r_side[LAST].neg;
            for (int k = 1; k <= CORDIC_STAGES; k++) begin
                r_flag[k] <= r_flag[k-1];
            end
        end
    end

    assign w_pitch = r_flag[CORDIC_STAGES].clamp ?
                     (r_flag[CORDIC_STAGES].neg ? QTE_PITCH_NEG : QTE_PITCH_POS) : w_pitch_c;
    assign w_data  = {w_yaw, w_pitch, w_roll};
    assign w_inc_v = r_v[NVAL-1];

    // output word plus skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (i_m_tready) begin
                r_od   <= r_sk_d;
                r_ou   <= r_sk_u;
                r_sk_v <= 1'b0;
            end
        end else if (!r_ov || i_m_tready) begin
            r_ov <= w_inc_v;
            r_od <= w_data;
            r_ou <= r_flag[CORDIC_STAGES].clamp;
        end else if (w_inc_v) begin
            r_sk_d <= w_data;
            r_sk_u <= r_flag[CORDIC_STAGES].clamp;
            r_sk_v <= 1'b1;
        end
    end

    assign o_m_tvalid   = r_ov;
    assign o_m_tdata    = r_od;
    assign o_m_tuser[0] = r_ou;

    `QTE_ASSERT_IMPL(a_clamp_pitch, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0],
        (o_m_tdata[31:16] == QTE_PITCH_POS) || (o_m_tdata[31:16] == QTE_PITCH_NEG),
        "clamped word without a quarter-turn pitch")
    `QTE_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready,
        "input stalled with empty output")
    `QTE_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, !o_s_tready && i_m_tready,
        o_s_tready && o_m_tvalid, "skid word not moved to output")

endmodule

// File: hw/rtl/qte_isqrt.sv
`timescale 1ns / 1ps
module qte_isqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [qte_pkg::QTE_RAD_W-1:0]  i_rad,
    output logic [qte_pkg::QTE_ROOT_W-1:0] o_root
);
    import qte_pkg::*;

    localparam int AW = QTE_RAD_W + 2;
    localparam int NS = QTE_ROOT_W;

    logic [AW-1:0]         r_rem  [NS-1];
    logic [QTE_ROOT_W-1:0] r_root [NS];

    // one result bit per stage, most significant first
    for (genvar j = 0; j < NS; j++) begin : g_step
        localparam int B = NS - 1 - j;
        logic [AW-1:0]         w_rem_in;
        logic [AW-1:0]         w_trial;
        logic [QTE_ROOT_W-1:0] w_root_in;
        logic                  w_take;

        if (j == 0) begin : g_first
            assign w_rem_in  = AW'(i_rad);
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_root_in = r_root[j-1];
        end

        assign w_trial = (AW'(w_root_in) << (B + 1)) + (AW'(1) << (2 * B));
        assign w_take  = (w_rem_in >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[j] <= w_take ? (w_root_in | (QTE_ROOT_W'(1) << B)) : w_root_in;
            end
        end

        if (j < NS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= w_take ? (w_rem_in - w_trial) : w_rem_in;
                end
            end
        end
    end

    assign o_root = r_root[NS-1];

endmodule

// File: hw/rtl/qte_cordic.sv
`timescale 1ns / 1ps
module qte_cordic #(
    parameter int STAGES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [qte_pkg::QTE_SUM_W-1:0] i_x,
    input  logic signed [qte_pkg::QTE_SUM_W-1:0] i_y,
    output logic [qte_pkg::QTE_ANGLE_W-1:0]      o_angle
);
    import qte_pkg::*;

    localparam int DW = QTE_CORDIC_W;

    logic signed [DW-1:0]  r_x    [STAGES+1];
    logic signed [DW-1:0]  r_y    [STAGES+1];
    logic [QTE_TURN_W-1:0] r_z    [STAGES+1];
    logic                  r_zero [STAGES+1];

    logic signed [DW-1:0]  w_xe;
    logic signed [DW-1:0]  w_ye;
    logic [QTE_TURN_W-1:0] w_turn;

    assign w_xe = {{(DW-QTE_SUM_W){i_x[QTE_SUM_W-1]}}, i_x};
    assign w_ye = {{(DW-QTE_SUM_W){i_y[QTE_SUM_W-1]}}, i_y};

    // fold the left half plane onto the right by a quarter turn
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (w_xe[DW-1]) begin
                if (!w_ye[DW-1]) begin
                    r_x[0] <= w_ye;
                    r_y[0] <= -w_xe;
                    r_z[0] <= QTE_QUARTER;
                end else begin
                    r_x[0] <= -w_ye;
                    r_y[0] <= w_xe;
                    r_z[0] <= QTE_MINUS_QTR;
                end
            end else begin
                r_x[0] <= w_xe;
                r_y[0] <= w_ye;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [DW-1:0]  w_dx;
        logic signed [DW-1:0]  w_dy;
        logic [QTE_TURN_W-1:0] w_at;

        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;
        assign w_at = (i < QTE_ATAN_LEN) ? qte_atan(5'(i)) : '0;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_y[i][DW-1]) begin
                    r_x[i+1] <= r_x[i] + w_dx;
                    r_y[i+1] <= r_y[i] - w_dy;
                    r_z[i+1] <= r_z[i] + w_at;
                end else begin
                    r_x[i+1] <= r_x[i] - w_dx;
                    r_y[i+1] <= r_y[i] + w_dy;
                    r_z[i+1] <= r_z[i] - w_at;
                end
            end
        end
    end

    assign w_turn  = r_z[STAGES] + QTE_ROUND;
    assign o_angle = r_zero[STAGES] ? '0 : w_turn[QTE_TURN_W-1 -: QTE_ANGLE_W];

endmodule
